[hw/rtl/assert_macros.svh]
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/dfr_pkg.sv]
// shared types, constants and microcode rom of the fraction reducer
`timescale 1ns / 1ps
package dfr_pkg;

  localparam int FRACTION_BITS = 32;
  localparam int VALUE_W       = 64;
  localparam int REG_W         = 31;
  localparam int MUL_W         = FRACTION_BITS + REG_W;
  localparam int CNT_MAX       = (FRACTION_BITS > REG_W) ? FRACTION_BITS : REG_W;
  localparam int CNT_W         = $clog2(CNT_MAX + 1);
  localparam int K_W           = $clog2(REG_W);
  localparam int PC_W          = 3;

  localparam logic [REG_W-1:0] PREC_RESET = REG_W'(1000000000);

  typedef logic [PC_W-1:0] pc_t;

  // program steps
  localparam pc_t PC_LOAD  = 3'd0;
  localparam pc_t PC_MUL   = 3'd1;
  localparam pc_t PC_ROUND = 3'd2;
  localparam pc_t PC_GCD   = 3'd3;
  localparam pc_t PC_GFORM = 3'd4;
  localparam pc_t PC_DIV   = 3'd5;
  localparam pc_t PC_OUT   = 3'd6;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MUL,
    OP_ROUND,
    OP_GCD,
    OP_GFORM,
    OP_DIV,
    OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_START,
    CND_LOOP,
    CND_GCD_RUN
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    pc_t    target;
  } uword_t;

  typedef struct packed {
    logic cnt_last;
    logic gcd_run;
  } dp_status_t;

  // one control word per step: datapath op, jump condition, jump target
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      PC_LOAD:  w = '{OP_LOAD,  CND_NO_START, PC_LOAD};
      PC_MUL:   w = '{OP_MUL,   CND_LOOP,     PC_MUL};
      PC_ROUND: w = '{OP_ROUND, CND_NEVER,    PC_LOAD};
      PC_GCD:   w = '{OP_GCD,   CND_GCD_RUN,  PC_GCD};
      PC_GFORM: w = '{OP_GFORM, CND_NEVER,    PC_LOAD};
      PC_DIV:   w = '{OP_DIV,   CND_LOOP,     PC_DIV};
      PC_OUT:   w = '{OP_OUT,   CND_ALWAYS,   PC_LOAD};
      default:  w = '{OP_LOAD,  CND_ALWAYS,   PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/dfr_seq.sv]
// step counter, microcode fetch and conditional jumps
`timescale 1ns / 1ps
module dfr_seq import dfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       busy_o
);

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   take;

  assign uw     = ucode_rom(pc_q);
  assign op_o   = uw.op;
  assign busy_o = (pc_q != PC_LOAD);

  always_comb begin
    case (uw.cond)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_START: take = !start_i;
      CND_LOOP:     take = !status_i.cnt_last;
      CND_GCD_RUN:  take = status_i.gcd_run;
      default:      take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_t'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[hw/rtl/dfr_dp.sv]
// datapath: shift-add multiplier, binary gcd, dual restoring divider
`timescale 1ns / 1ps
module dfr_dp import dfr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_op_e                    op_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [REG_W-1:0]          prec_i,
  output dp_status_t                status_o,
  output logic                      done_o,
  output logic [REG_W-1:0]          den_o,
  output logic [REG_W-1:0]          num_o
);

  logic [MUL_W-1:0] mul_q, mul_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REG_W-1:0] n_q, n_d, a_q, a_d, b_q, b_d, g_q, g_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [REG_W-1:0] qp_q, qp_d, qn_q, qn_d, rp_q, rp_d, rn_q, rn_d;
  logic [REG_W-1:0] den_q, den_d, num_q, num_d;
  logic             done_q, done_d;

  logic [REG_W:0]   mul_sum;
  logic [REG_W-1:0] n_round;
  logic             gcd_run;
  logic [REG_W-1:0] diff_ab, diff_ba;
  logic [REG_W:0]   tp, tn;
  logic             fit_p, fit_n;

  // add precision when the low bit is set, then shift the whole product right
  assign mul_sum = {1'b0, mul_q[MUL_W-1:FRACTION_BITS]}
                 + (mul_q[0] ? {1'b0, prec_i} : {(REG_W+1){1'b0}});
  // round half up: carry in the top discarded bit
  assign n_round = REG_W'({1'b0, mul_q[MUL_W-1:FRACTION_BITS]}
                 + {{REG_W{1'b0}}, mul_q[FRACTION_BITS-1]});

  assign gcd_run = (a_q != '0) && (b_q != '0);
  assign diff_ab = a_q - b_q;
  assign diff_ba = b_q - a_q;

  assign tp    = {rp_q, qp_q[REG_W-1]};
  assign tn    = {rn_q, qn_q[REG_W-1]};
  assign fit_p = (tp >= {1'b0, g_q});
  assign fit_n = (tn >= {1'b0, g_q});

  assign status_o.cnt_last = (cnt_q == CNT_W'(1));
  assign status_o.gcd_run  = gcd_run;

  always_comb begin
    mul_d  = mul_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    qp_d   = qp_q;
    qn_d   = qn_q;
    rp_d   = rp_q;
    rn_d   = rn_q;
    den_d  = den_q;
    num_d  = num_q;
    done_d = 1'b0;
    case (op_i)
      OP_LOAD: begin
        mul_d = {{REG_W{1'b0}}, value_i[FRACTION_BITS-1:0]};
        cnt_d = CNT_W'(FRACTION_BITS);
      end
      OP_MUL: begin
        mul_d = {mul_sum, mul_q[FRACTION_BITS-1:1]};
        cnt_d = cnt_q - 1'b1;
      end
      OP_ROUND: begin
        n_d = n_round;
        a_d = n_round;
        b_d = prec_i;
        k_d = '0;
      end
      OP_GCD: begin
        if (gcd_run) begin
          if (!a_q[0] && !b_q[0]) begin
            a_d = a_q >> 1;
            b_d = b_q >> 1;
            k_d = K_W'(k_q + 1'b1);
          end else if (!a_q[0]) begin
            a_d = a_q >> 1;
          end else if (!b_q[0]) begin
            b_d = b_q >> 1;
          end else if (a_q >= b_q) begin
            a_d = diff_ab >> 1;
          end else begin
            b_d = diff_ba >> 1;
          end
        end
      end
      OP_GFORM: begin
        g_d   = (a_q | b_q) << k_q;
        qp_d  = prec_i;
        qn_d  = n_q;
        rp_d  = '0;
        rn_d  = '0;
        cnt_d = CNT_W'(REG_W);
      end
      OP_DIV: begin
        rp_d  = fit_p ? REG_W'(tp - {1'b0, g_q}) : tp[REG_W-1:0];
        rn_d  = fit_n ? REG_W'(tn - {1'b0, g_q}) : tn[REG_W-1:0];
        qp_d  = {qp_q[REG_W-2:0], fit_p};
        qn_d  = {qn_q[REG_W-2:0], fit_n};
        cnt_d = cnt_q - 1'b1;
      end
      OP_OUT: begin
        // zero precision gives a zero gcd: both fields read zero
        den_d  = (g_q == '0) ? '0 : qp_q;
        num_d  = (g_q == '0) ? '0 : qn_q;
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    cnt_q <= cnt_d;
    n_q   <= n_d;
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    g_q   <= g_d;
    qp_q  <= qp_d;
    qn_q  <= qn_d;
    rp_q  <= rp_d;
    rn_q  <= rn_d;
    den_q <= den_d;
    num_q <= num_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign den_o  = den_q;
  assign num_o  = num_q;

endmodule

[hw/rtl/decimal_fraction_reducer.sv]
// top level: precision register, microcode sequencer and datapath
//
// channel   direction  handshake                   payload
// command   in         start_i high, busy_o low    value_i
// result    out        done_o one-cycle strobe     denominator_o, numerator_o
// config    in         cfg_valid_i and cfg_ready_o cfg_data_i (precision)
//
// a transaction keeps busy_o high through FRACTION_BITS multiply steps,
// 31 divide steps, G binary gcd steps counting the exit check (G at most 62),
// plus three single steps (round, gcd form, output).
// the binary gcd loop sets the variable part; the next command is taken in
// the cycle the result strobe is shown. reset is asynchronous, active low,
// and restores precision to 1000000000. results cannot be stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module decimal_fraction_reducer import dfr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [REG_W-1:0]          cfg_data_i,
  output logic                      done_o,
  output logic [REG_W-1:0]          denominator_o,
  output logic [REG_W-1:0]          numerator_o
);

  logic [REG_W-1:0] prec_q, prec_d;
  dp_status_t       status;
  dp_op_e           op;

  assign cfg_ready_o = !busy_o;
  assign prec_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : prec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= PREC_RESET;
    end else begin
      prec_q <= prec_d;
    end
  end

  dfr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy_o)
  );

  dfr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .value_i  (value_i),
    .prec_i   (prec_q),
    .status_o (status),
    .done_o   (done_o),
    .den_o    (denominator_o),
    .num_o    (numerator_o)
  );

  `ASSERT_PROP(a_done_idle, done_o |-> !busy_o, "result strobe while busy")
  `ASSERT_PROP(a_start_busy, (start_i && !busy_o) |=> busy_o, "command not taken")
  `ASSERT_PROP(a_done_after_busy, done_o |-> $past(busy_o), "result without command")
  `ASSERT_PROP(a_zero_den, (done_o && denominator_o == '0) |-> (numerator_o == '0),
    "zero denominator with nonzero numerator")
  `ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o, "result strobe in reset")

endmodule

[bench/tb_top.sv]
// self-checking testbench of the decimal fraction reducer
`timescale 1ns / 1ps
module tb_top;
  import dfr_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [REG_W-1:0]   denominator;
    logic [REG_W-1:0]   numerator;
  } reduced_fraction_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic [VALUE_W-1:0] value_i     = '0;
  logic               cfg_valid_i = 1'b0;
  logic [REG_W-1:0]   cfg_data_i  = '0;
  logic               busy_o;
  logic               cfg_ready_o;
  logic               done_o;
  logic [REG_W-1:0]   denominator_o;
  logic [REG_W-1:0]   numerator_o;

  reduced_fraction_t pending_fractions[$];
  logic [REG_W-1:0]  precision_shadow = PREC_RESET;
  int unsigned       mismatch_count   = 0;
  bit                gaps_on          = 1'b1;

  decimal_fraction_reducer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .denominator_o (denominator_o),
    .numerator_o   (numerator_o)
  );

  always #2 clk_i = ~clk_i;

  // round the scaled fraction half up, then divide both terms by their gcd
  function automatic reduced_fraction_t reduce_fraction(input logic [VALUE_W-1:0] v,
                                                        input logic [REG_W-1:0] p);
    logic [127:0]      scaled;
    logic [REG_W-1:0]  n;
    logic [REG_W-1:0]  a;
    logic [REG_W-1:0]  b;
    logic [REG_W-1:0]  r;
    reduced_fraction_t res;
    scaled = 128'(v[FRACTION_BITS-1:0]) * 128'(p) + (128'(1) << (FRACTION_BITS - 1));
    n = REG_W'(scaled >> FRACTION_BITS);
    a = n;
    b = p;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    res.value = v;
    if (a == '0) begin
      // only a zero precision gets here
      res.denominator = '0;
      res.numerator   = '0;
    end else begin
      res.denominator = p / a;
      res.numerator   = n / a;
    end
    return res;
  endfunction

  // results cannot be held off, so compare at every strobe
  always @(negedge clk_i) begin
    reduced_fraction_t want;
    if (rst_ni && done_o) begin
      if (pending_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %0d / %0d", numerator_o, denominator_o);
      end else begin
        want = pending_fractions.pop_front();
        if (denominator_o !== want.denominator || numerator_o !== want.numerator) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch value=%h precision=%0d: expected %0d / %0d, got %0d / %0d",
                     want.value, precision_shadow, want.numerator, want.denominator,
                     numerator_o, denominator_o);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // called at a rising edge, returns at the edge where the transaction is taken
  task automatic send_value(input logic [VALUE_W-1:0] v);
    start_i <= 1'b1;
    value_i <= v;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    pending_fractions.push_back(reduce_fraction(v, precision_shadow));
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic write_precision(input logic [REG_W-1:0] p);
    wait_drained();
    repeat ($urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i      <= 1'b0;
    precision_shadow  = p;
  endtask

  task automatic send_with_gap(input logic [VALUE_W-1:0] v);
    send_value(v);
    idle_gap(pick_gap());
  endtask

  // fraction bits biased toward zero, one, the half point and coarse values
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v[31:0] = $urandom_range(0, 255);
      1: v[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 255);
      2: v[31:0] = 32'h8000_0000 + $urandom_range(0, 511) - 256;
      3: v[31:0] = v[31:0] & ~((32'd1 << $urandom_range(4, 31)) - 1);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_reset_precision();
    send_with_gap(64'h0);
    send_with_gap(64'hFFFF_FFFF_FFFF_FFFF);
    send_with_gap(64'h8000_0000_0000_0000);
    send_with_gap(64'h7FFF_FFFF_FFFF_FFFF);
    send_with_gap(64'h0000_0000_8000_0000);
    send_with_gap(64'h0000_0000_0000_0001);
    send_with_gap(64'hFFFF_FFF0_7FFF_FFFF);
    send_with_gap(64'h1234_5678_4000_0000);
  endtask

  // half-up ties at tiny precisions
  task automatic test_rounding_ties();
    write_precision(REG_W'(1));
    send_with_gap(64'h0000_0000_7FFF_FFFF);
    send_with_gap(64'h0000_0000_8000_0000);
    send_with_gap(64'hFFFF_FFFF_0000_0000);
    write_precision(REG_W'(2));
    send_with_gap(64'h0000_0000_4000_0000);
    send_with_gap(64'h0000_0000_3FFF_FFFF);
    send_with_gap(64'h0000_0000_C000_0000);
  endtask

  task automatic test_out_of_range_precision();
    write_precision(REG_W'(0));
    send_with_gap(64'h0000_0000_8000_0000);
    send_with_gap(64'hFFFF_FFFF_FFFF_FFFF);
    write_precision({REG_W{1'b1}});
    send_with_gap(64'hFFFF_FFFF_FFFF_FFFF);
    send_with_gap(64'h0000_0000_8000_0000);
    send_with_gap(64'h0000_0000_0000_0001);
    write_precision(REG_W'(1073741824));
    send_with_gap(64'h0000_0000_0000_0004);
    send_with_gap(64'hFFFF_FFFF_FFFF_FFFE);
  endtask

  task automatic test_random_phases();
    logic [REG_W-1:0] p;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:  p = REG_W'(1000000000);
        1:  p = REG_W'(1);
        2:  p = REG_W'(1073741824);
        3:  p = REG_W'(0);
        4:  p = {REG_W{1'b1}};
        5:  p = REG_W'(10);
        6:  p = REG_W'(360360);
        7:  p = REG_W'(1000000);
        8:  p = REG_W'($urandom_range(1, 1000));
        9:  p = REG_W'($urandom_range(1, 1073741824));
        10: p = REG_W'($urandom);
        default: p = REG_W'(1000);
      endcase
      write_precision(p);
      gaps_on = (phase % 4) != 3;
      repeat (100) send_with_gap(random_value());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_precision();
    test_rounding_ties();
    test_out_of_range_precision();
    test_random_phases();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_fractions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_seq.sv
hw/rtl/dfr_dp.sv
hw/rtl/decimal_fraction_reducer.sv
bench/tb_top.sv
